// ----- rtl/flag_delimited_frame_receiver_unit_macros.svh -----
// Assertion helpers used by the frame receiver unit.
// In synthesis builds the helpers expand to nothing.
`ifndef FLAG_DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define FLAG_DELIMITED_FRAME_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define FDFR_ASSERT(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed: %m");

// A condition that, once true, must be followed by another in the next cycle.
`define FDFR_ASSERT_NEXT(label, clk, rstn, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cons)) \
        else $error("assertion failed: %m");

`else

`define FDFR_ASSERT(label, clk, rstn, cond)
`define FDFR_ASSERT_NEXT(label, clk, rstn, trig, cons)

`endif

`endif

// ----- rtl/fdfr_pkg.sv -----
`default_nettype none

package fdfr_pkg;

    // Longest frame delivered, closing flag included.
    localparam int FRAME_BYTES = 64;

    // Frame store geometry.
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LEN_W       = ADDR_W + 1;
    localparam int BYTE_W      = 8;

    // Flag that opens and closes a frame.
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;

    // Length limits: the store limit in the width of the length counter, the frame limit one bit wider.
    localparam logic [LEN_W:0]   FRAME_LIMIT = (LEN_W + 1)'(FRAME_BYTES);
    localparam logic [LEN_W-1:0] STORE_LIMIT = LEN_W'(STORE_DEPTH);

    // Receiver sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_FLAG
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/flag_delimited_frame_receiver_unit.sv -----
// Flag delimited frame receiver.
// Input channel s_*: one received byte per transfer, with s_chunk_end marking the
// last byte of a chunk. Output channel m_*: one frame byte per transfer, with
// m_frame_last on the closing flag. Configuration: cfg_we writes cfg_wdata into
// framing_enable, to be done only while the block is idle.
// Framing mode: bytes before an opening 0x7E flag are dropped; the flag and
// following bytes are kept in a 64 entry frame store. A further 0x7E causes the
// whole frame, both flags included, to be delivered. A frame that would exceed
// the frame size is dropped silently and hunting resumes.
// Raw mode: each byte appears on the output in the cycle after its transfer, with
// m_frame_last equal to s_chunk_end.
// Sequencing: a byte that produces no output, or a raw byte, leaves the sequencer
// idle and ready for the next byte whenever the output register is free. After the
// closing flag, each stored byte is read from the frame store, then loaded into the
// output register, and the closing flag follows; no input is taken meanwhile.
// A stalled output (m_ready low) holds the output register and pauses both the
// input and frame delivery; nothing is lost.
// Reset (aresetn low, synchronous) returns to hunting with framing enabled and
// an empty output register. The frame store needs no clearing.
`default_nettype none
`include "flag_delimited_frame_receiver_unit_macros.svh"

module flag_delimited_frame_receiver_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       s_chunk_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_frame_byte,
    output logic            m_frame_last
);

    fdfr_pkg::state_t state_reg, state_next;

    logic                          framing_enable_reg;
    logic                          in_frame_reg, in_frame_next;
    logic [fdfr_pkg::LEN_W-1:0]    frame_length_reg, frame_length_next;
    logic [fdfr_pkg::ADDR_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                          m_valid_reg, m_valid_next;
    logic [fdfr_pkg::BYTE_W-1:0]   m_byte_reg, m_byte_next;
    logic                          m_last_reg, m_last_next;

    logic                          out_free;
    logic                          s_fire;
    logic                          load_out;
    logic                          is_flag;
    logic                          overrun;
    logic                          more_bytes;

    logic                          ram_wr_en;
    logic [fdfr_pkg::ADDR_W-1:0]   ram_wr_addr;
    logic [fdfr_pkg::BYTE_W-1:0]   ram_wr_data;
    logic                          ram_rd_en;
    logic [fdfr_pkg::BYTE_W-1:0]   ram_rd_data;

    // Frame store.
    fdfr_ram #(
        .WIDTH (fdfr_pkg::BYTE_W),
        .DEPTH (fdfr_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    // Handshake and decode helpers.
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == fdfr_pkg::ST_IDLE) && out_free;
    assign s_fire     = s_valid && s_ready;
    assign is_flag    = (s_rx_byte == fdfr_pkg::FLAG_BYTE);
    assign overrun    = (({1'b0, frame_length_reg} + 1'b1) >= fdfr_pkg::FRAME_LIMIT)
                        || (frame_length_reg >= fdfr_pkg::STORE_LIMIT);
    assign more_bytes = (({1'b0, rd_idx_reg} + 1'b1) < frame_length_reg);

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fdfr_pkg::ST_IDLE: begin
                if (s_fire && framing_enable_reg && in_frame_reg && is_flag) begin
                    state_next = fdfr_pkg::ST_READ;
                end
            end
            fdfr_pkg::ST_READ: begin
                state_next = fdfr_pkg::ST_EMIT;
            end
            fdfr_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = more_bytes ? fdfr_pkg::ST_READ : fdfr_pkg::ST_FLAG;
                end
            end
            fdfr_pkg::ST_FLAG: begin
                if (out_free) begin
                    state_next = fdfr_pkg::ST_IDLE;
                end
            end
            default: state_next = fdfr_pkg::ST_IDLE;
        endcase
    end

    // Datapath control: store writes, reads, counters and output loads.
    always_comb begin
        in_frame_next     = in_frame_reg;
        frame_length_next = frame_length_reg;
        rd_idx_next       = rd_idx_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = frame_length_reg[fdfr_pkg::ADDR_W-1:0];
        ram_wr_data       = s_rx_byte;
        ram_rd_en         = 1'b0;
        load_out          = 1'b0;
        m_byte_next       = m_byte_reg;
        m_last_next       = m_last_reg;
        unique case (state_reg)
            fdfr_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (!framing_enable_reg) begin
                        load_out    = 1'b1;
                        m_byte_next = s_rx_byte;
                        m_last_next = s_chunk_end;
                    end else if (!in_frame_reg) begin
                        if (is_flag) begin
                            ram_wr_en         = 1'b1;
                            ram_wr_addr       = '0;
                            frame_length_next = fdfr_pkg::LEN_W'(1);
                            in_frame_next     = 1'b1;
                        end
                    end else if (is_flag) begin
                        in_frame_next = 1'b0;
                        rd_idx_next   = '0;
                    end else if (overrun) begin
                        in_frame_next     = 1'b0;
                        frame_length_next = '0;
                    end else begin
                        ram_wr_en         = 1'b1;
                        frame_length_next = frame_length_reg + 1'b1;
                    end
                end
            end
            fdfr_pkg::ST_READ: begin
                ram_rd_en = 1'b1;
            end
            fdfr_pkg::ST_EMIT: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    m_byte_next = ram_rd_data;
                    m_last_next = 1'b0;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            fdfr_pkg::ST_FLAG: begin
                if (out_free) begin
                    load_out          = 1'b1;
                    m_byte_next       = fdfr_pkg::FLAG_BYTE;
                    m_last_next       = 1'b1;
                    frame_length_next = '0;
                end
            end
            default: begin
                load_out = 1'b0;
            end
        endcase
    end

    // The output register fills on a load and empties on a transfer.
    always_comb begin
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= fdfr_pkg::ST_IDLE;
            framing_enable_reg <= 1'b1;
            in_frame_reg       <= 1'b0;
            frame_length_reg   <= '0;
            rd_idx_reg         <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg        <= state_next;
            in_frame_reg     <= in_frame_next;
            frame_length_reg <= frame_length_next;
            rd_idx_reg       <= rd_idx_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_we) begin
                framing_enable_reg <= cfg_wdata;
            end
        end
    end

    // Output payload registers.
    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_frame_last = m_last_reg;

    // Input is taken only while the sequencer is idle.
    `FDFR_ASSERT(a_ready_only_idle, aclk, aresetn,
        !s_ready || (state_reg == fdfr_pkg::ST_IDLE))
    // The store is written only by input transfers.
    `FDFR_ASSERT(a_write_only_idle, aclk, aresetn,
        !ram_wr_en || (s_fire && (state_reg == fdfr_pkg::ST_IDLE)))
    // The held length always leaves room for the closing flag.
    `FDFR_ASSERT(a_length_bound, aclk, aresetn,
        ({1'b0, frame_length_reg} < fdfr_pkg::FRAME_LIMIT))
    // A read is always followed by the emit step.
    `FDFR_ASSERT_NEXT(a_read_then_emit, aclk, aresetn,
        (state_reg == fdfr_pkg::ST_READ), (state_reg == fdfr_pkg::ST_EMIT))
    // The closing flag leaves the sequencer with a last marker on the output.
    `FDFR_ASSERT_NEXT(a_flag_marks_last, aclk, aresetn,
        ((state_reg == fdfr_pkg::ST_FLAG) && out_free),
        (m_valid && m_frame_last && (state_reg == fdfr_pkg::ST_IDLE)))

endmodule

`default_nettype wire

// ----- rtl/fdfr_ram.sv -----
`default_nettype none

module fdfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
